// ===== sv/three_point_circle_arc_assert.svh =====
// assertion macros for the circle arc block
`ifndef THREE_POINT_CIRCLE_ARC_ASSERT_SVH
`define THREE_POINT_CIRCLE_ARC_ASSERT_SVH

`ifndef SYNTHESIS
`define TPCA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpca assertion failed");
`define TPCA_ASSERT_LAT(lbl, ante, n, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error("tpca latency assertion failed");
`else
`define TPCA_ASSERT_IMP(lbl, ante, cons)
`define TPCA_ASSERT_LAT(lbl, ante, n, cons)
`endif

`endif

// ===== sv/tpca_pkg.sv =====
`default_nettype none

package tpca_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int C_W        = 24;
    localparam int R_W        = 24;
    localparam int A_W        = 16;
    localparam int E_W        = 18;

    localparam int NUM_W      = 54;
    localparam int DEN_W      = 37;
    localparam int VEC_W      = NUM_W + 1;

    localparam int CORDIC_N   = 30;
    localparam int NORM_R     = 6;
    localparam int NORM_L     = 5;
    localparam int NORM_N     = NORM_R + NORM_L;
    localparam int SQ_N       = 25;
    localparam int SQ_W       = 2 * SQ_N;

    localparam int FRONT_LAT  = 6;
    localparam int DIV_LAT    = NUM_W + 2;
    localparam int RAD_LAT    = SQ_N + 4;
    localparam int COR_LAT    = NORM_N + CORDIC_N + 3;
    localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT + COR_LAT + 2;

    localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004755, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

endpackage

`default_nettype wire

// ===== sv/tpca_div.sv =====
`default_nettype none

module tpca_div
    import tpca_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_valid,
    output logic signed [NUM_W-1:0] o_quo
);

    logic [DIV_LAT-1:0]  r_v;
    logic [NUM_W-1:0]    r_a   [NUM_W+1];
    logic [DEN_W-1:0]    r_rem [NUM_W+1];
    logic [DEN_W-1:0]    r_den [NUM_W+1];
    logic [NUM_W:0]      r_neg;
    logic signed [NUM_W-1:0] r_quo;
    logic [NUM_W-1:0]    n_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0]   <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_rem[0] <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_num[NUM_W-1];
    end

    // one quotient bit per stage, restoring
    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_step
        logic [DEN_W:0] n_sh;
        logic [DEN_W:0] n_diff;
        logic           n_ge;
        assign n_sh   = {r_rem[gi], r_a[gi][NUM_W-1]};
        assign n_ge   = n_sh >= {1'b0, r_den[gi]};
        assign n_diff = n_sh - {1'b0, r_den[gi]};
        always_ff @(posedge i_clk) begin
            r_rem[gi+1] <= n_ge ? n_diff[DEN_W-1:0] : n_sh[DEN_W-1:0];
            r_a[gi+1]   <= {r_a[gi][NUM_W-2:0], n_ge};
            r_den[gi+1] <= r_den[gi];
            r_neg[gi+1] <= r_neg[gi];
        end
    end

    // floor for negative numerators
    assign n_qm = r_a[NUM_W] + NUM_W'(r_rem[NUM_W] != '0);

    always_ff @(posedge i_clk) begin
        r_quo <= r_neg[NUM_W] ? -$signed(n_qm) : $signed(r_a[NUM_W]);
    end

    assign o_valid = r_v[DIV_LAT-1];
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

// ===== sv/tpca_rad.sv =====
`default_nettype none

module tpca_rad
    import tpca_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_ux,
    input  logic signed [NUM_W-1:0] i_uy,
    output logic                    o_valid,
    output logic [R_W-1:0]          o_rad,
    output logic                    o_clip
);

    localparam logic signed [NUM_W-1:0] U_LIM   = NUM_W'(2 ** R_W);
    localparam logic [SQ_N:0]           RAD_MAX = (SQ_N+1)'(2 ** R_W - 1);

    logic [RAD_LAT-1:0]      r_v;
    logic signed [SQ_N-1:0]  r_ux;
    logic signed [SQ_N-1:0]  r_uy;
    logic signed [SQ_W-1:0]  r_sqx;
    logic signed [SQ_W-1:0]  r_sqy;
    logic [SQ_N+2:0]         r_big;
    logic [SQ_W-1:0]         r_s   [SQ_N+1];
    logic [SQ_N+1:0]         r_rem [SQ_N+1];
    logic [SQ_N-1:0]         r_r   [SQ_N+1];
    logic [R_W-1:0]          r_rad;
    logic                    r_clip;
    logic [SQ_N:0]           n_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[RAD_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux     <= i_ux[SQ_N-1:0];
        r_uy     <= i_uy[SQ_N-1:0];
        r_big[0] <= (i_ux >= U_LIM) || (i_ux <= -U_LIM) || (i_uy >= U_LIM) || (i_uy <= -U_LIM);
        r_sqx    <= r_ux * r_ux;
        r_sqy    <= r_uy * r_uy;
        r_big[1] <= r_big[0];
        r_s[0]   <= SQ_W'(r_sqx) + SQ_W'(r_sqy);
        r_rem[0] <= '0;
        r_r[0]   <= '0;
        r_big[2] <= r_big[1];
    end

    // two radicand bits per stage
    for (genvar gi = 0; gi < SQ_N; gi++) begin : g_step
        logic [SQ_N+3:0] n_sh;
        logic [SQ_N+3:0] n_trial;
        logic [SQ_N+3:0] n_diff;
        logic            n_ge;
        assign n_sh    = {r_rem[gi], r_s[gi][SQ_W-1 -: 2]};
        assign n_trial = {2'b00, r_r[gi], 2'b01};
        assign n_ge    = n_sh >= n_trial;
        assign n_diff  = n_sh - n_trial;
        always_ff @(posedge i_clk) begin
            r_rem[gi+1]  <= n_ge ? n_diff[SQ_N+1:0] : n_sh[SQ_N+1:0];
            r_r[gi+1]    <= {r_r[gi][SQ_N-2:0], n_ge};
            r_s[gi+1]    <= {r_s[gi][SQ_W-3:0], 2'b00};
            r_big[gi+3]  <= r_big[gi+2];
        end
    end

    // round half up: remainder above root
    assign n_rnd = {1'b0, r_r[SQ_N]} + (SQ_N+1)'(r_rem[SQ_N] > {2'b00, r_r[SQ_N]});

    always_ff @(posedge i_clk) begin
        if (r_big[SQ_N+2] || (n_rnd > RAD_MAX)) begin
            r_rad  <= '1;
            r_clip <= 1'b1;
        end else begin
            r_rad  <= n_rnd[R_W-1:0];
            r_clip <= 1'b0;
        end
    end

    assign o_valid = r_v[RAD_LAT-1];
    assign o_rad   = r_rad;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

// ===== sv/tpca_cordic.sv =====
`default_nettype none

module tpca_cordic
    import tpca_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [VEC_W-1:0]      i_x,
    input  logic signed [VEC_W-1:0]      i_y,
    output logic                         o_valid,
    output logic signed [ANGLE_BITS-1:0] o_angle
);

    logic [COR_LAT-1:0]  r_v;
    logic [VEC_W-1:0]    r_ax [NORM_N+1];
    logic [VEC_W-1:0]    r_ay [NORM_N+1];
    logic [NORM_N:0]     r_yn;
    logic [NORM_N:0]     r_zf;
    logic [NORM_N:0]     r_zero;
    logic signed [31:0]  r_x [CORDIC_N+1];
    logic signed [31:0]  r_y [CORDIC_N+1];
    logic [31:0]         r_z [CORDIC_N+1];
    logic [CORDIC_N:0]   r_zc;
    logic signed [ANGLE_BITS-1:0] r_angle;
    logic [31:0]         n_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[COR_LAT-2:0], i_valid};
        end
    end

    // fold into the right half plane, keep magnitudes
    always_ff @(posedge i_clk) begin
        r_ax[0]   <= i_x[VEC_W-1] ? VEC_W'(-i_x) : VEC_W'(i_x);
        r_ay[0]   <= i_y[VEC_W-1] ? VEC_W'(-i_y) : VEC_W'(i_y);
        r_yn[0]   <= i_y[VEC_W-1] ^ i_x[VEC_W-1];
        r_zf[0]   <= i_x[VEC_W-1];
        r_zero[0] <= (i_x == '0) && (i_y == '0);
    end

    // normalise larger magnitude into [2^28, 2^29)
    for (genvar gi = 0; gi < NORM_N; gi++) begin : g_norm
        localparam int  K     = (gi < NORM_R) ? (32 >> gi) : (16 >> (gi - NORM_R));
        localparam bit  RIGHT = (gi < NORM_R);
        logic [VEC_W-1:0] n_m;
        logic             n_sh;
        assign n_m  = r_ax[gi] | r_ay[gi];
        assign n_sh = RIGHT ? ((n_m >> (28 + K)) != '0) : ((n_m >> (29 - K)) == '0);
        always_ff @(posedge i_clk) begin
            if (!n_sh) begin
                r_ax[gi+1] <= r_ax[gi];
                r_ay[gi+1] <= r_ay[gi];
            end else if (RIGHT) begin
                r_ax[gi+1] <= r_ax[gi] >> K;
                r_ay[gi+1] <= r_ay[gi] >> K;
            end else begin
                r_ax[gi+1] <= r_ax[gi] << K;
                r_ay[gi+1] <= r_ay[gi] << K;
            end
            r_yn[gi+1]   <= r_yn[gi];
            r_zf[gi+1]   <= r_zf[gi];
            r_zero[gi+1] <= r_zero[gi];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]  <= $signed(32'(r_ax[NORM_N]));
        r_y[0]  <= r_yn[NORM_N] ? -$signed(32'(r_ay[NORM_N])) : $signed(32'(r_ay[NORM_N]));
        r_z[0]  <= r_zf[NORM_N] ? 32'h8000_0000 : 32'h0;
        r_zc[0] <= r_zero[NORM_N];
    end

    for (genvar gi = 0; gi < CORDIC_N; gi++) begin : g_iter
        logic signed [31:0] n_xs;
        logic signed [31:0] n_ys;
        assign n_xs = r_x[gi] >>> gi;
        assign n_ys = r_y[gi] >>> gi;
        always_ff @(posedge i_clk) begin
            if (r_y[gi] > 0) begin
                r_x[gi+1] <= r_x[gi] + n_ys;
                r_y[gi+1] <= r_y[gi] - n_xs;
                r_z[gi+1] <= r_z[gi] + ATAN_TAB[gi];
            end else begin
                r_x[gi+1] <= r_x[gi] - n_ys;
                r_y[gi+1] <= r_y[gi] + n_xs;
                r_z[gi+1] <= r_z[gi] - ATAN_TAB[gi];
            end
            r_zc[gi+1] <= r_zc[gi];
        end
    end

    assign n_t = r_z[CORDIC_N] + (32'd1 << (31 - ANGLE_BITS));

    always_ff @(posedge i_clk) begin
        r_angle <= r_zc[CORDIC_N] ? '0 : $signed(n_t[31 -: ANGLE_BITS]);
    end

    assign o_valid = r_v[COR_LAT-1];
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ===== sv/three_point_circle_arc.sv =====
// channel   | direction | handshake          | payload
// request   | in        | start / busy       | i_first_x .. i_last_y
// result    | out       | o_valid (1 cycle)  | o_center_x .. o_clipped
//
// one request per clock, busy stays low; each result passes through the stages
// (6 front, 56 divider stages, 1 offset, 44 angle stages, 1 arc select)
// the angle pipeline sets the latency; the radius path is delayed to match it
// synchronous active-low reset clears only the valid bits
// the result is shown for one cycle and cannot be held off
`default_nettype none
`include "three_point_circle_arc_assert.svh"

module three_point_circle_arc
    import tpca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [15:0]    i_first_x,
    input  logic signed [15:0]    i_first_y,
    input  logic signed [15:0]    i_mid_x,
    input  logic signed [15:0]    i_mid_y,
    input  logic signed [15:0]    i_last_x,
    input  logic signed [15:0]    i_last_y,
    output logic                  o_valid,
    output logic signed [C_W-1:0] o_center_x,
    output logic signed [C_W-1:0] o_center_y,
    output logic [R_W-1:0]        o_circle_radius,
    output logic signed [A_W-1:0] o_arc_start,
    output logic signed [E_W-1:0] o_arc_end,
    output logic                  o_collinear,
    output logic                  o_clipped
);

    localparam int RAD_GAP = COR_LAT - RAD_LAT;
    localparam logic signed [VEC_W-1:0] C_MAX = VEC_W'(2 ** (C_W - 1) - 1);
    localparam logic signed [VEC_W-1:0] C_MIN = -VEC_W'(2 ** (C_W - 1));

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [16:0] bx;
        logic signed [16:0] by;
        logic signed [16:0] cx;
        logic signed [16:0] cy;
    } t_side;

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic                  clip;
        logic                  coll;
    } t_ctr;

    typedef struct packed {
        logic [R_W-1:0] rad;
        logic           clip;
    } t_rad;

    // front pipeline
    logic [FRONT_LAT-1:0]    r_fv;
    t_side                   r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic signed [33:0]      r2_pbc, r2_pbyc, r2_bxx, r2_byy, r2_cxx, r2_cyy;
    logic signed [35:0]      r3_det, r4_det;
    logic signed [34:0]      r3_b2, r3_c2;
    logic signed [51:0]      r4_m1, r4_m2, r4_m3, r4_m4;
    logic signed [52:0]      r5_nx, r5_ny;
    logic [35:0]             r5_adet;
    logic                    r5_dneg, r5_coll, r6_coll;
    logic signed [NUM_W-1:0] r6_numx, r6_numy;
    logic [DEN_W-1:0]        r6_den;
    logic signed [34:0]      n_dd;
    logic signed [NUM_W-1:0] n_nx2, n_ny2, n_ad;

    // divider and alignment
    logic                    n_ux_v, n_uy_v;
    logic signed [NUM_W-1:0] n_ux, n_uy;
    t_side                   r_sd [DIV_LAT];
    logic [DIV_LAT-1:0]      r_cl;

    // offset stage
    logic                    r_pv;
    logic signed [NUM_W-1:0] r_ux, r_uy;
    logic signed [VEC_W-1:0] r_v1x, r_v1y, r_v2x, r_v2y, r_v3x, r_v3y;
    t_ctr                    r_pctr;
    logic signed [VEC_W-1:0] n_cx, n_cy;
    t_ctr                    n_ctr;

    t_ctr                    r_cd [COR_LAT];
    t_rad                    r_rd [RAD_GAP];

    logic                    n_rad_v, n_rad_clip;
    logic [R_W-1:0]          n_rad;
    logic                    n_a1_v, n_a2_v, n_a3_v;
    logic signed [ANGLE_BITS-1:0] n_a1, n_a2, n_a3;

    // arc select
    logic [ANGLE_BITS-1:0]          n_d21, n_d31;
    logic signed [ANGLE_BITS-1:0]   n_st, n_en;
    logic signed [ANGLE_BITS+1:0]   n_enw;
    t_ctr                           n_fc;
    t_rad                           n_fr;
    logic                           r_ov;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_fv <= {r_fv[FRONT_LAT-2:0], start & ~busy};
            r_pv <= n_ux_v & n_uy_v;
            r_ov <= n_a1_v & n_a2_v & n_a3_v;
        end
    end

    assign n_dd  = 35'(r2_pbc) - 35'(r2_pbyc);
    assign n_nx2 = NUM_W'(r5_nx) <<< 1;
    assign n_ny2 = NUM_W'(r5_ny) <<< 1;
    assign n_ad  = $signed(NUM_W'(r5_adet));

    always_ff @(posedge i_clk) begin
        r1_side.x1 <= i_first_x;
        r1_side.y1 <= i_first_y;
        r1_side.bx <= 17'(i_mid_x) - 17'(i_first_x);
        r1_side.by <= 17'(i_mid_y) - 17'(i_first_y);
        r1_side.cx <= 17'(i_last_x) - 17'(i_first_x);
        r1_side.cy <= 17'(i_last_y) - 17'(i_first_y);

        r2_side <= r1_side;
        r2_pbc  <= r1_side.bx * r1_side.cy;
        r2_pbyc <= r1_side.by * r1_side.cx;
        r2_bxx  <= r1_side.bx * r1_side.bx;
        r2_byy  <= r1_side.by * r1_side.by;
        r2_cxx  <= r1_side.cx * r1_side.cx;
        r2_cyy  <= r1_side.cy * r1_side.cy;

        r3_side <= r2_side;
        r3_det  <= {n_dd[34], n_dd} <<< 1;
        r3_b2   <= 35'(r2_bxx) + 35'(r2_byy);
        r3_c2   <= 35'(r2_cxx) + 35'(r2_cyy);

        r4_side <= r3_side;
        r4_det  <= r3_det;
        r4_m1   <= r3_side.cy * r3_b2;
        r4_m2   <= r3_side.by * r3_c2;
        r4_m3   <= r3_side.bx * r3_c2;
        r4_m4   <= r3_side.cx * r3_b2;

        r5_side <= r4_side;
        r5_nx   <= 53'(r4_m1) - 53'(r4_m2);
        r5_ny   <= 53'(r4_m3) - 53'(r4_m4);
        r5_adet <= r4_det[35] ? 36'(-r4_det) : 36'(r4_det);
        r5_dneg <= r4_det[35];
        r5_coll <= r4_det == '0;

        // make the divisor positive, add half for rounding
        r6_side <= r5_side;
        r6_numx <= r5_dneg ? (n_ad - n_nx2) : (n_nx2 + n_ad);
        r6_numy <= r5_dneg ? (n_ad - n_ny2) : (n_ny2 + n_ad);
        r6_den  <= {r5_adet, 1'b0};
        r6_coll <= r5_coll;
    end

    tpca_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv[FRONT_LAT-1]),
        .i_num   (r6_numx),
        .i_den   (r6_den),
        .o_valid (n_ux_v),
        .o_quo   (n_ux)
    );

    tpca_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv[FRONT_LAT-1]),
        .i_num   (r6_numy),
        .i_den   (r6_den),
        .o_valid (n_uy_v),
        .o_quo   (n_uy)
    );

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r6_side;
        r_cl    <= {r_cl[DIV_LAT-2:0], r6_coll};
        for (int i = 1; i < DIV_LAT; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    // centre saturation
    always_comb begin
        n_cx       = VEC_W'(r_sd[DIV_LAT-1].x1) + VEC_W'(n_ux);
        n_cy       = VEC_W'(r_sd[DIV_LAT-1].y1) + VEC_W'(n_uy);
        n_ctr.clip = 1'b0;
        n_ctr.coll = r_cl[DIV_LAT-1];
        if (n_cx > C_MAX) begin
            n_ctr.cx   = C_MAX[C_W-1:0];
            n_ctr.clip = 1'b1;
        end else if (n_cx < C_MIN) begin
            n_ctr.cx   = C_MIN[C_W-1:0];
            n_ctr.clip = 1'b1;
        end else begin
            n_ctr.cx   = n_cx[C_W-1:0];
        end
        if (n_cy > C_MAX) begin
            n_ctr.cy   = C_MAX[C_W-1:0];
            n_ctr.clip = 1'b1;
        end else if (n_cy < C_MIN) begin
            n_ctr.cy   = C_MIN[C_W-1:0];
            n_ctr.clip = 1'b1;
        end else begin
            n_ctr.cy   = n_cy[C_W-1:0];
        end
    end

    // vectors from centre to each point, y flipped
    always_ff @(posedge i_clk) begin
        r_ux   <= n_ux;
        r_uy   <= n_uy;
        r_pctr <= n_ctr;
        r_v1x  <= -VEC_W'(n_ux);
        r_v1y  <= VEC_W'(n_uy);
        r_v2x  <= VEC_W'(r_sd[DIV_LAT-1].bx) - VEC_W'(n_ux);
        r_v2y  <= VEC_W'(n_uy) - VEC_W'(r_sd[DIV_LAT-1].by);
        r_v3x  <= VEC_W'(r_sd[DIV_LAT-1].cx) - VEC_W'(n_ux);
        r_v3y  <= VEC_W'(n_uy) - VEC_W'(r_sd[DIV_LAT-1].cy);
    end

    tpca_rad u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_ux    (r_ux),
        .i_uy    (r_uy),
        .o_valid (n_rad_v),
        .o_rad   (n_rad),
        .o_clip  (n_rad_clip)
    );

    tpca_cordic u_cor_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_x     (r_v1x),
        .i_y     (r_v1y),
        .o_valid (n_a1_v),
        .o_angle (n_a1)
    );

    tpca_cordic u_cor_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_x     (r_v2x),
        .i_y     (r_v2y),
        .o_valid (n_a2_v),
        .o_angle (n_a2)
    );

    tpca_cordic u_cor_last (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_x     (r_v3x),
        .i_y     (r_v3y),
        .o_valid (n_a3_v),
        .o_angle (n_a3)
    );

    always_ff @(posedge i_clk) begin
        r_cd[0]      <= r_pctr;
        r_rd[0].rad  <= n_rad;
        r_rd[0].clip <= n_rad_clip & n_rad_v | n_rad_clip;
        for (int i = 1; i < COR_LAT; i++) begin
            r_cd[i] <= r_cd[i-1];
        end
        for (int i = 1; i < RAD_GAP; i++) begin
            r_rd[i] <= r_rd[i-1];
        end
    end

    // arc direction from the middle point
    always_comb begin
        n_fc  = r_cd[COR_LAT-1];
        n_fr  = r_rd[RAD_GAP-1];
        n_d21 = ANGLE_BITS'(n_a2 - n_a1);
        n_d31 = ANGLE_BITS'(n_a3 - n_a1);
        if (n_d31 > n_d21) begin
            n_st = n_a1;
            n_en = n_a3;
        end else begin
            n_st = n_a3;
            n_en = n_a1;
        end
        n_enw = (ANGLE_BITS+2)'(n_en);
        if (n_en < n_st) begin
            n_enw = n_enw + (ANGLE_BITS+2)'(2 ** ANGLE_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fc.coll) begin
            o_center_x      <= '0;
            o_center_y      <= '0;
            o_circle_radius <= '0;
            o_arc_start     <= '0;
            o_arc_end       <= '0;
            o_collinear     <= 1'b1;
            o_clipped       <= 1'b0;
        end else begin
            o_center_x      <= n_fc.cx;
            o_center_y      <= n_fc.cy;
            o_circle_radius <= n_fr.rad;
            o_arc_start     <= A_W'(n_st);
            o_arc_end       <= E_W'(n_enw);
            o_collinear     <= 1'b0;
            o_clipped       <= n_fc.clip | n_fr.clip;
        end
    end

    assign o_valid = r_ov;

    `TPCA_ASSERT_LAT(a_latency, start && !busy, TOTAL_LAT, o_valid)
    `TPCA_ASSERT_IMP(a_no_spurious, o_valid, $past(start, TOTAL_LAT))
    `TPCA_ASSERT_IMP(a_coll_zero, o_valid && o_collinear, (o_circle_radius == '0) && !o_clipped && (o_arc_end == '0))
    `TPCA_ASSERT_IMP(a_arc_order, o_valid && !o_collinear, $signed(o_arc_end) >= $signed(o_arc_start))

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import tpca_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = TOTAL_LAT + 20;
    localparam int N_RANDOM     = 1500;
    localparam int N_STEADY     = 200;

    typedef struct {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic [R_W-1:0]        rad;
        logic signed [A_W-1:0] a_start;
        logic signed [E_W-1:0] a_end;
        logic                  coll;
        logic                  clip;
    } t_arc;

    typedef struct {
        logic signed [15:0] p [6];
        bit                 typed;
        t_arc               res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] pt [6];
    logic               o_valid;
    logic signed [C_W-1:0] o_center_x, o_center_y;
    logic [R_W-1:0]     o_circle_radius;
    logic signed [A_W-1:0] o_arc_start;
    logic signed [E_W-1:0] o_arc_end;
    logic               o_collinear, o_clipped;

    t_arc   arc_q [$];
    int     errors;
    int     cycles;
    bit     typed_next;
    t_arc   typed_res;
    t_row   rows [$];

    three_point_circle_arc u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(pt[0]), .i_first_y(pt[1]), .i_mid_x(pt[2]), .i_mid_y(pt[3]),
        .i_last_x(pt[4]), .i_last_y(pt[5]),
        .o_valid(o_valid), .o_center_x(o_center_x), .o_center_y(o_center_y),
        .o_circle_radius(o_circle_radius), .o_arc_start(o_arc_start),
        .o_arc_end(o_arc_end), .o_collinear(o_collinear), .o_clipped(o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic bit [31:0] vec_turns(longint x, longint y);
        bit [31:0] z;
        longint unsigned ax, ay, m;
        bit yneg;
        longint xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        yneg = (y < 0);
        ax = x;
        ay = yneg ? -y : y;
        m = (ax > ay) ? ax : ay;
        while (m >= (64'd1 << 29)) begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 28)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        x = ax;
        y = yneg ? -longint'(ay) : longint'(ay);
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint angle_round(bit [31:0] z);
        bit [31:0] t;
        longint s;
        t = z + (32'd1 << (31 - ANGLE_BITS));
        s = t >> (32 - ANGLE_BITS);
        if (s >= (64'sd1 << (ANGLE_BITS - 1))) s -= (64'sd1 << ANGLE_BITS);
        return s;
    endfunction

    function automatic longint unsigned sqrt_round(longint unsigned s);
        longint unsigned r, b, rem;
        r = 0;
        b = 64'd1 << 50;
        rem = s;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic t_arc circle_arc(logic signed [15:0] p [6]);
        t_arc res;
        longint x1, y1, bx, by, cx, cy, det, b2, c2, nx, ny, ux, uy;
        longint ccx, ccy, a1, a2, a3, st, en, d21, d31, turn;
        longint unsigned rad;
        bit clip;
        x1 = p[0]; y1 = p[1];
        bx = p[2] - x1; by = p[3] - y1;
        cx = p[4] - x1; cy = p[5] - y1;
        det = 2 * (bx * cy - by * cx);
        turn = 64'sd1 << ANGLE_BITS;
        clip = 0;
        res = '{default: '0};
        if (det == 0) begin
            res.coll = 1'b1;
            return res;
        end
        b2 = bx * bx + by * by;
        c2 = cx * cx + cy * cy;
        nx = cy * b2 - by * c2;
        ny = bx * c2 - cx * b2;
        if (det < 0) begin
            det = -det; nx = -nx; ny = -ny;
        end
        ux = div_floor(2 * nx + det, 2 * det);
        uy = div_floor(2 * ny + det, 2 * det);
        ccx = x1 + ux;
        ccy = y1 + uy;
        if (ccx > 8388607) begin ccx = 8388607; clip = 1; end
        if (ccx < -8388608) begin ccx = -8388608; clip = 1; end
        if (ccy > 8388607) begin ccy = 8388607; clip = 1; end
        if (ccy < -8388608) begin ccy = -8388608; clip = 1; end
        if (ux >= 16777216 || ux <= -16777216 || uy >= 16777216 || uy <= -16777216) begin
            rad = 16777215; clip = 1;
        end else begin
            rad = sqrt_round(ux * ux + uy * uy);
            if (rad > 16777215) begin rad = 16777215; clip = 1; end
        end
        a1 = angle_round(vec_turns(-ux, uy));
        a2 = angle_round(vec_turns(bx - ux, uy - by));
        a3 = angle_round(vec_turns(cx - ux, uy - cy));
        d21 = (a2 - a1) & (turn - 1);
        d31 = (a3 - a1) & (turn - 1);
        if (d31 > d21) begin
            st = a1; en = a3;
        end else begin
            st = a3; en = a1;
        end
        if (en < st) en += turn;
        res.cx = ccx[C_W-1:0];
        res.cy = ccy[C_W-1:0];
        res.rad = rad[R_W-1:0];
        res.a_start = st[A_W-1:0];
        res.a_end = en[E_W-1:0];
        res.clip = clip;
        return res;
    endfunction

    // accepted request: queue its expected circle
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            arc_q.insert(arc_q.size(), typed_next ? typed_res : circle_arc(pt));
    end

    always @(posedge i_clk) begin
        t_arc e;
        if (i_rst_n && o_valid) begin
            if (arc_q.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                e = arc_q.pop_front();
                if (o_center_x !== e.cx || o_center_y !== e.cy || o_circle_radius !== e.rad
                    || o_arc_start !== e.a_start || o_arc_end !== e.a_end
                    || o_collinear !== e.coll || o_clipped !== e.clip) begin
                    $display("%0t: mismatch exp c=(%0d,%0d) r=%0d a=%0d..%0d col=%0b clip=%0b",
                             $time, e.cx, e.cy, e.rad, e.a_start, e.a_end, e.coll, e.clip);
                    $display("%0t:          act c=(%0d,%0d) r=%0d a=%0d..%0d col=%0b clip=%0b",
                             $time, o_center_x, o_center_y, o_circle_radius, o_arc_start,
                             o_arc_end, o_collinear, o_clipped);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send(logic signed [15:0] p [6], bit typed, t_arc res, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pt = p;
        typed_next = typed;
        typed_res = res;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic int idle_gap(bit quiet);
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 9);
    endfunction

    task automatic add_row(int a, int b, int c, int d, int e, int f, bit coll);
        t_row r;
        r.p = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f)};
        r.typed = coll;
        r.res = '{default: '0};
        r.res.coll = coll;
        rows.insert(rows.size(), r);
    endtask

    initial begin
        logic signed [15:0] p [6];
        t_arc none;
        int kind, span, bxv, byv, dx, dy, k;
        none = '{default: '0};
        errors = 0;
        cycles = 0;
        start = 1'b0;
        typed_next = 1'b0;
        typed_res = none;
        pt = '{default: '0};
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // collinear and coincident points
        add_row(0, 0, 16, 0, 32, 0, 1);
        add_row(5, 7, 5, 7, 100, -3, 1);
        add_row(-9, -9, -9, -9, -9, -9, 1);
        add_row(-32768, -32768, 0, 0, 32767, 32767, 1);
        add_row(-32768, 0, -32768, 100, -32768, 32767, 1);
        // axis-aligned chords, both directions
        add_row(16, 0, 0, 16, -16, 0, 0);
        add_row(16, 0, 0, -16, -16, 0, 0);
        add_row(0, 0, 0, 160, 160, 160, 0);
        add_row(0, 0, 160, 0, 160, 160, 0);
        add_row(100, 50, -100, 50, 0, -70, 0);
        // extremes of the coordinate range
        add_row(-32768, -32768, 32767, -32768, -32768, 32767, 0);
        add_row(32767, 32767, -32768, 32767, 32767, -32768, 0);
        add_row(-32768, 32767, 32767, 32767, 32767, -32768, 0);
        // near-collinear points, some saturating centre and radius, and small triangles
        add_row(-32768, -32768, 32767, 32767, 32767, 32766, 0);
        add_row(-32768, 0, 0, 1, 32767, 0, 0);
        add_row(0, 0, 1, 0, 0, 1, 0);
        add_row(1, 1, 2, 1, 1, 2, 0);
        add_row(-1, -1, -32768, 5, 32767, 3, 0);

        foreach (rows[i])
            send(rows[i].p, rows[i].typed, rows[i].res, idle_gap(0));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                @(negedge i_clk);
                start = 1'b0;
                while (arc_q.size() != 0) @(posedge i_clk);
            end
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                foreach (p[j]) p[j] = rnd16();
            end else if (kind < 7) begin
                // small triangle around a random point
                span = 1 << $urandom_range(2, 12);
                p[0] = 16'($signed($urandom_range(0, 60000)) - 30000);
                p[1] = 16'($signed($urandom_range(0, 60000)) - 30000);
                for (int j = 2; j < 6; j++)
                    p[j] = p[j % 2] + 16'($signed($urandom_range(0, 2 * span)) - span);
            end else if (kind < 9) begin
                // collinear or coincident
                p[0] = 16'($signed($urandom_range(0, 2000)) - 1000);
                p[1] = 16'($signed($urandom_range(0, 2000)) - 1000);
                bxv = $signed($urandom_range(0, 20)) - 10;
                byv = $signed($urandom_range(0, 20)) - 10;
                k = $signed($urandom_range(0, 200)) - 100;
                p[2] = p[0] + 16'(bxv * $urandom_range(0, 100));
                p[3] = p[1] + 16'(byv * ((p[2] - p[0]) == 0 ? $urandom_range(0, 100)
                                          : (p[2] - p[0]) / (bxv == 0 ? 1 : bxv)));
                p[4] = p[0] + 16'(bxv * k);
                p[5] = p[1] + 16'(byv * k);
                if (kind == 8) begin
                    p[2] = p[0]; p[3] = p[1];
                end
            end else begin
                // shared axis-aligned chords
                foreach (p[j]) p[j] = 16'($signed($urandom_range(0, 4000)) - 2000);
                dx = $urandom_range(0, 1);
                if (dx) p[2] = p[0]; else p[3] = p[1];
                dy = $urandom_range(0, 1);
                if (dy) p[5] = p[3]; else p[4] = p[2];
            end
            send(p, 1'b0, none, idle_gap(n >= N_RANDOM - N_STEADY));
        end
        @(negedge i_clk);
        start = 1'b0;
        while (arc_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
